FILE: design/log_return_volatility_defines.svh
// Assertion macros for the top RTL file of the log return volatility block.
`ifndef LOG_RETURN_VOLATILITY_DEFINES_SVH
`define LOG_RETURN_VOLATILITY_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked at every rising clock edge outside reset.
`define LRV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define LRV_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define LRV_ASSERT(lbl, prop, msg)
`define LRV_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/lrv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrv_pkg
// Shared constants, state and command types of the log return volatility block.
// ----------------------------------------------------------------------------
package lrv_pkg;

	localparam int MAX_PRICES = 1048576;
	localparam int CNT_W      = $clog2(MAX_PRICES) + 1;
	localparam int FRAC_BITS  = 28;
	localparam int NORM_STEPS = 5;
	localparam int DIV_STEPS  = 96;
	localparam int SQRT_STEPS = 32;
	localparam int STEP_W     = 7;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FEW  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE, S_CHKIN, S_SKIP, S_NORM, S_SQR, S_LN, S_CUR, S_SQ, S_ACC, S_CHK,
		S_MA0, S_MA1, S_MB0, S_MB1, S_MB2, S_SUB, S_DIV, S_SQI, S_SQRT,
		S_OUT_OK, S_OUT_ZERO, S_OUT_FEW
	} lrv_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SKIP, OP_NORM, OP_SQR, OP_LN, OP_CUR, OP_SQ, OP_ACC,
		OP_MA0, OP_MA1, OP_MB0, OP_MB1, OP_MB2, OP_SUB, OP_DIV, OP_SQI, OP_SQRT,
		OP_OUT_OK, OP_OUT_ZERO, OP_OUT_FEW
	} lrv_op_t;

	typedef struct packed {
		lrv_op_t    op;
		logic [2:0] norm_idx;
	} lrv_cmd_t;

	typedef struct packed {
		logic zero_price;
		logic over_max;
		logic is_last;
		logic few;
		logic bad;
	} lrv_stat_t;

endpackage
`default_nettype wire

FILE: design/lrv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrv_ctrl
// Sequencer that steps the datapath through log, accumulate and final stages.
// ----------------------------------------------------------------------------
module lrv_ctrl
	import lrv_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	output lrv_cmd_t       cmd,
	input  wire lrv_stat_t stat
);

	lrv_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.norm_idx = step_q[2:0];
		busy         = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHKIN;
				end
			end
			S_CHKIN: state_d = (stat.zero_price || stat.over_max) ? S_SKIP : S_NORM;
			S_SKIP: begin
				cmd.op  = OP_SKIP;
				state_d = S_CHK;
			end
			S_NORM: begin
				cmd.op = OP_NORM;
				if (step_q == STEP_W'(NORM_STEPS - 1)) state_d = S_SQR;
			end
			S_SQR: begin
				cmd.op = OP_SQR;
				if (step_q == STEP_W'(FRAC_BITS - 1)) state_d = S_LN;
			end
			S_LN: begin
				cmd.op  = OP_LN;
				state_d = S_CUR;
			end
			S_CUR: begin
				cmd.op  = OP_CUR;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op  = OP_SQ;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op  = OP_ACC;
				state_d = S_CHK;
			end
			S_CHK: begin
				priority if (!stat.is_last) state_d = S_IDLE;
				else if (stat.bad)          state_d = S_OUT_ZERO;
				else if (stat.few)          state_d = S_OUT_FEW;
				else                        state_d = S_MA0;
			end
			S_MA0: begin
				cmd.op  = OP_MA0;
				state_d = S_MA1;
			end
			S_MA1: begin
				cmd.op  = OP_MA1;
				state_d = S_MB0;
			end
			S_MB0: begin
				cmd.op  = OP_MB0;
				state_d = S_MB1;
			end
			S_MB1: begin
				cmd.op  = OP_MB1;
				state_d = S_MB2;
			end
			S_MB2: begin
				cmd.op  = OP_MB2;
				state_d = S_SUB;
			end
			S_SUB: begin
				cmd.op  = OP_SUB;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = S_SQI;
			end
			S_SQI: begin
				cmd.op  = OP_SQI;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				if (step_q == STEP_W'(SQRT_STEPS - 1)) state_d = S_OUT_OK;
			end
			S_OUT_OK: begin
				cmd.op  = OP_OUT_OK;
				state_d = S_IDLE;
			end
			S_OUT_ZERO: begin
				cmd.op  = OP_OUT_ZERO;
				state_d = S_IDLE;
			end
			S_OUT_FEW: begin
				cmd.op  = OP_OUT_FEW;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		step_d = (state_d != state_q) ? '0 : step_q + STEP_W'(1);
	end

endmodule
`default_nettype wire

FILE: design/lrv_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrv_dp
// Log, return accumulation, divider and square root datapath.
// ----------------------------------------------------------------------------
module lrv_dp
	import lrv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] price,
	input  wire logic        last,
	input  wire lrv_cmd_t    cmd,
	output lrv_stat_t        stat,
	output logic [31:0]      volatility,
	output logic [1:0]       status,
	output logic             done
);

	logic [31:0]        price_q;
	logic               last_q;
	logic [31:0]        y_q;
	logic [4:0]         sh_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic               neg_q;
	logic [64:0]        lnp_q;
	logic signed [32:0] diff_q;
	logic [63:0]        sq_q;
	logic [31:0]        prev_q;
	logic signed [55:0] rsum_q;
	logic [63:0]        ssum_q;
	logic [CNT_W-1:0]   count_q;
	logic               bad_q;
	logic [111:0]       acc_q;
	logic [111:0]       a_q;
	logic               tneg_q;
	logic [95:0]        dv_q;
	logic [CNT_W-1:0]   rem_q;
	logic [63:0]        sx_q;
	logic [63:0]        sres_q;
	logic [63:0]        sbit_q;
	logic               sat_q;
	logic [31:0]        vol_q;
	logic [1:0]         stat_q;
	logic               done_q;

	// Combinational helpers for the step in flight.
	logic [4:0]         amt;
	logic [31:0]        ymask;
	logic [63:0]        ysq;
	logic [32:0]        ysh;
	logic signed [33:0] l2;
	logic [32:0]        mag;
	logic [64:0]        rnd;
	logic [31:0]        cur;
	logic [32:0]        rm33;
	logic [31:0]        rm;
	logic [55:0]        smag;
	logic [27:0]        s0, s1;
	logic [CNT_W-1:0]   dsr;
	logic [CNT_W:0]     trial;
	logic [63:0]        rb;
	logic [52:0]        pm_lo, pm_hi;
	logic [55:0]        ps00, ps01, ps11;

	always_comb begin
		amt   = 5'(5'd16 >> cmd.norm_idx);
		ymask = ~(32'hFFFF_FFFF >> amt);
		ysq   = y_q * y_q;
		ysh   = ysq[63:31];
		l2    = {6'sd15 - $signed({1'b0, sh_q}), frac_q};
		mag   = l2[33] ? 33'(-l2) : l2[32:0];
		rnd   = lnp_q + (65'd1 << 35);
		cur   = neg_q ? 32'(-{3'b0, rnd[64:36]}) : {3'b0, rnd[64:36]};
		rm33  = diff_q[32] ? 33'(-diff_q) : diff_q;
		rm    = rm33[31:0];
		smag  = rsum_q[55] ? 56'(-rsum_q) : rsum_q;
		s0    = smag[27:0];
		s1    = smag[55:28];
		dsr   = count_q - CNT_W'(1);
		trial = {rem_q, dv_q[95]};
		rb    = sres_q + sbit_q;
		pm_lo = count_q * ssum_q[31:0];
		pm_hi = count_q * ssum_q[63:32];
		ps00  = s0 * s0;
		ps01  = s0 * s1;
		ps11  = s1 * s1;
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				price_q <= price;
				last_q  <= last;
				y_q     <= price;
				sh_q    <= '0;
				frac_q  <= '0;
			end
			OP_NORM: begin
				if ((y_q & ymask) == '0) begin
					y_q  <= y_q << amt;
					sh_q <= sh_q + amt;
				end
			end
			OP_SQR: begin
				frac_q <= {frac_q[FRAC_BITS-2:0], ysh[32]};
				y_q    <= ysh[32] ? ysh[32:1] : ysh[31:0];
			end
			OP_LN: begin
				neg_q <= l2[33];
				lnp_q <= mag * LN2_Q32;
			end
			OP_CUR: begin
				diff_q <= $signed({cur[31], cur}) - $signed({prev_q[31], prev_q});
				prev_q <= cur;
			end
			OP_SQ:  sq_q <= {32'b0, rm} * {32'b0, rm};
			OP_MA0: acc_q <= 112'(pm_lo);
			OP_MA1: acc_q <= acc_q + (112'(pm_hi) << 32);
			OP_MB0: begin
				a_q   <= acc_q << 16;
				acc_q <= 112'(ps00);
			end
			OP_MB1: acc_q <= acc_q + (112'(ps01) << 29);
			OP_MB2: acc_q <= acc_q + (112'(ps11) << 56);
			OP_SUB: begin
				tneg_q <= acc_q > a_q;
				dv_q   <= 96'((a_q - acc_q) >> 16);
				rem_q  <= '0;
			end
			OP_DIV: begin
				if (trial >= {1'b0, dsr}) begin
					rem_q <= CNT_W'(trial - {1'b0, dsr});
					dv_q  <= {dv_q[94:0], 1'b1};
				end else begin
					rem_q <= trial[CNT_W-1:0];
					dv_q  <= {dv_q[94:0], 1'b0};
				end
			end
			OP_SQI: begin
				sx_q   <= dv_q[63:0];
				sat_q  <= |dv_q[95:64];
				sres_q <= '0;
				sbit_q <= 64'd1 << 62;
			end
			OP_SQRT: begin
				if (sx_q >= rb) begin
					sx_q   <= sx_q - rb;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			default: begin
			end
		endcase
	end

	// Series accumulators, cleared when a result goes out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsum_q  <= '0;
			ssum_q  <= '0;
			count_q <= '0;
			bad_q   <= 1'b0;
			done_q  <= 1'b0;
			stat_q  <= ST_OK;
			vol_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (cmd.op)
				OP_SKIP: begin
					if (count_q < CNT_W'(MAX_PRICES)) begin
						bad_q   <= 1'b1;
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_ACC: begin
					if (count_q != '0) begin
						rsum_q <= rsum_q + 56'(diff_q);
						ssum_q <= ssum_q + ((sq_q + 64'd32768) >> 16);
					end
					count_q <= count_q + CNT_W'(1);
				end
				OP_OUT_OK, OP_OUT_ZERO, OP_OUT_FEW: begin
					done_q  <= 1'b1;
					rsum_q  <= '0;
					ssum_q  <= '0;
					count_q <= '0;
					bad_q   <= 1'b0;
					if (cmd.op == OP_OUT_OK) begin
						stat_q <= ST_OK;
						vol_q  <= tneg_q ? 32'd0 : (sat_q ? 32'hFFFF_FFFF : sres_q[31:0]);
					end else begin
						stat_q <= (cmd.op == OP_OUT_ZERO) ? ST_ZERO : ST_FEW;
						vol_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// The first price of a series leaves prev_q at the log just formed;
	// a new series starts its first return against that value only after it
	// is overwritten, which the count check above takes care of.
	always_comb begin
		stat.zero_price = (price_q == '0);
		stat.over_max   = (count_q >= CNT_W'(MAX_PRICES));
		stat.is_last    = last_q;
		stat.few        = (count_q < CNT_W'(2));
		stat.bad        = bad_q;
	end

	assign volatility = vol_q;
	assign status     = stat_q;
	assign done       = done_q;

endmodule
`default_nettype wire

FILE: design/log_return_volatility.sv
`timescale 1ns / 1ps
`default_nettype none
`include "log_return_volatility_defines.svh"
// ----------------------------------------------------------------------------
// log_return_volatility
// Historical volatility of log returns over a series of Q16.16 prices.
// ----------------------------------------------------------------------------
// Usage: drive price and last and raise start; the item is taken at the rising
// edge where start is high and busy is low. Busy stays high while the item is
// processed. A valid price keeps busy high through an input check, five
// normalization steps, 28 squaring steps of the 32x32 log multiplier, and
// steps to scale, subtract, square, accumulate and check for the end of the
// series. A zero price, or one past the series limit, skips the log steps and
// goes straight to the end check.
// When last is set, one result item follows: volatility and status are valid
// for exactly one cycle while done is high. The closing computation runs five
// partial products, a subtract, a 96-step bit-serial divider and a 32-step
// square root, and only then does done rise for a full series.
// A series with a zero price or fewer than two prices reports right after the
// end check, without the closing computation.
// The receiver cannot stall; the result is held in output registers, and the
// next item may be started in the cycle that done is high.
// Reset clears the sequencer and all series accumulators at once.
module log_return_volatility
	import lrv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] price,
	input  wire logic        last,
	output logic [31:0]      volatility,
	output logic [1:0]       status,
	output logic             done
);

	lrv_cmd_t  cmd;
	lrv_stat_t stat;

	// The sequencer issues one datapath command per cycle.
	lrv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	// The datapath holds the series state and the arithmetic units.
	lrv_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.price      (price),
		.last       (last),
		.cmd        (cmd),
		.stat       (stat),
		.volatility (volatility),
		.status     (status),
		.done       (done)
	);

	// A result always comes out after the sequencer has returned to idle.
	`LRV_ASSERT(a_done_idle, done |-> !busy, "result strobe while busy")
	// An accepted item always makes the block busy in the next cycle.
	`LRV_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item left no work")
	// Status never carries an unused code.
	`LRV_NEVER(a_status_code, done && (status > ST_ZERO), "unused status code")
	// A nonzero volatility only comes with a good status.
	`LRV_ASSERT(a_vol_ok, (done && (volatility != '0)) |-> (status == ST_OK),
		"volatility with error status")

endmodule
`default_nettype wire

FILE: tb/sv/lrv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrv_checker
// Tracks accepted prices, keeps its own series sums and compares every done
// strobe with the volatility and status that the series should produce.
// ----------------------------------------------------------------------------
module lrv_checker
	import lrv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] price,
	input  logic        last,
	input  logic [31:0] volatility,
	input  logic [1:0]  status,
	input  logic        done,
	output int          fail_count,
	output int          pending
);

	logic signed [31:0] prev_ln;
	logic signed [55:0] ret_sum;
	logic [63:0]        sq_sum;
	logic [20:0]        n_prices;
	logic               zero_seen;
	logic [31:0]        vol_q[$];
	logic [1:0]         stat_q[$];

	// Natural log of a Q16.16 price in Q8.24.
	function automatic logic signed [31:0] ln_q824(input logic [31:0] p);
		int          k;
		logic [63:0] y;
		logic [63:0] frac;
		longint      l2;
		logic [63:0] mag;
		logic [63:0] r;
		k = 31;
		while (k > 0 && p[k] == 1'b0) k--;
		y = 64'(p) << (31 - k);
		frac = 0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			y = (y * y) >> 31;
			frac = frac << 1;
			if (y >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				y = y >> 1;
			end
		end
		l2 = longint'(k - 16) * (longint'(1) << FRAC_BITS) + longint'(frac);
		mag = (l2 < 0) ? 64'(-l2) : 64'(l2);
		r = (mag * 64'(LN2_Q32) + (64'd1 << 35)) >> 36;
		return (l2 < 0) ? -32'(r) : 32'(r);
	endfunction

	function automatic logic [31:0] series_volatility(input logic [20:0] n);
		logic [127:0] a;
		logic [127:0] b;
		logic [127:0] q;
		logic [63:0]  smag;
		logic [63:0]  x;
		logic [63:0]  res;
		logic [63:0]  bitv;
		a = (128'(n) * 128'(sq_sum)) << 16;
		smag = ret_sum[55] ? 64'(-ret_sum) : 64'(ret_sum);
		b = 128'(smag) * 128'(smag);
		if (b > a) return 32'd0;
		q = (a - b) / (128'(n - 1) << 16);
		if (q[127:64] != 0) return 32'hFFFF_FFFF;
		x = q[63:0];
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
	endfunction

	task automatic report(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic take_price(input logic [31:0] p, input logic l);
		logic signed [31:0] cur;
		logic signed [63:0] r;
		logic [63:0]        rm;
		logic [31:0]        v;
		logic [1:0]         s;
		if (n_prices < MAX_PRICES) begin
			if (p == 0) begin
				zero_seen = 1'b1;
			end else begin
				cur = ln_q824(p);
				if (n_prices > 0) begin
					r = 64'(cur) - 64'(prev_ln);
					rm = r[63] ? -r : r;
					ret_sum = ret_sum + 56'(r);
					sq_sum = sq_sum + ((rm * rm + (64'd1 << 15)) >> 16);
				end
				prev_ln = cur;
			end
			n_prices++;
		end
		if (l) begin
			v = 0;
			s = ST_OK;
			if (zero_seen) s = ST_ZERO;
			else if (n_prices < 2) s = ST_FEW;
			else v = series_volatility(n_prices);
			vol_q = {vol_q, v};
			stat_q = {stat_q, s};
			prev_ln = 0;
			ret_sum = 0;
			sq_sum = 0;
			n_prices = 0;
			zero_seen = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ln = 0;
			ret_sum = 0;
			sq_sum = 0;
			n_prices = 0;
			zero_seen = 1'b0;
		end else begin
			if (done) begin
				if (vol_q.size() == 0) begin
					report("result with no series pending");
				end else begin
					if (volatility !== vol_q[0])
						report($sformatf("volatility %h, want %h", volatility, vol_q[0]));
					if (status !== stat_q[0])
						report($sformatf("status %0d, want %0d", status, stat_q[0]));
					void'(vol_q.pop_front());
					void'(stat_q.pop_front());
				end
			end
			if (start && !busy) take_price(price, last);
		end
		pending = vol_q.size();
	end

	initial fail_count = 0;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives series of prices into the volatility block and reports the verdict
// that the checker reaches.
// ----------------------------------------------------------------------------
module tb;
	import lrv_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] price;
	logic        last;
	logic [31:0] volatility;
	logic [1:0]  status;
	logic        done;
	int          fail_count;
	int          pending;
	int          idle_pct;

	log_return_volatility DUT (.*);

	lrv_checker u_checker (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Sends one item and waits for the edge that accepts it. The sender may
	// first idle for a random number of cycles, with start held low.
	task automatic send(input logic [31:0] p, input logic l);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		price <= p;
		last  <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
		// The item was taken at this edge. Start is left high; the block is
		// busy now, and the next call or the caller drives it again.
	endtask

	// Random price: mostly near a level fixed for the series so the series look
	// like real markets, sometimes any 32-bit value or a tiny one, rarely zero.
	function automatic logic [31:0] pick_price(input logic [31:0] level);
		int sel;
		sel = $urandom_range(99);
		if (sel < 2) return 32'd0;
		if (sel < 15) return $urandom;
		if (sel < 20) return 32'($urandom_range(1, 255));
		return level + 32'($urandom_range(4095)) - 32'd2048;
	endfunction

	task automatic random_series(input int len);
		logic [31:0] level;
		level = {8'd0, 24'($urandom)} | 32'h0001_0000;
		for (int i = 0; i < len; i++)
			send(pick_price(level), i == len - 1);
	endtask

	initial begin
		int sent;
		start    = 1'b0;
		price    = 32'd0;
		last     = 1'b0;
		idle_pct = 27;
		arst_n   = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: lone price, extremes of the price range, a zero price,
		// a price after a zero, flat prices, huge swings and small swings.
		send(32'h0001_0000, 1'b1);
		send(32'hFFFF_FFFF, 1'b0);
		send(32'h0000_0001, 1'b1);
		send(32'h0000_0001, 1'b0);
		send(32'hFFFF_FFFF, 1'b0);
		send(32'h0000_0001, 1'b0);
		send(32'hFFFF_FFFF, 1'b1);
		send(32'h0001_0000, 1'b0);
		send(32'd0, 1'b0);
		send(32'h0002_0000, 1'b1);
		send(32'd0, 1'b1);
		send(32'h8000_0000, 1'b0);
		send(32'h8000_0000, 1'b0);
		send(32'h8000_0000, 1'b1);
		send(32'h0001_8000, 1'b0);
		send(32'h0001_0000, 1'b0);
		send(32'h0001_8000, 1'b1);
		send(32'h5555_5555, 1'b0);
		send(32'hAAAA_AAAA, 1'b1);

		// Random series in three idling phases.
		sent = 0;
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 27 : (ph == 1) ? 78 : 0;
			while (sent < 650 * (ph + 1)) begin
				int len;
				len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
				random_series(len);
				sent += len;
			end
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// About 2000 items plus idling, even if every one closed a series with the
	// full closing computation, fit well inside this bound.
	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
